>>> hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for concurrent assertions clocked on clk, reset on rst_n.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising clock edge outside reset.
`define TAM_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("tam assertion failed");

// Condition must never be seen outside reset.
`define TAM_NEVER(lbl, cond) `TAM_ASSERT(lbl, !(cond))

`endif

>>> hw/rtl/tam_pkg.sv
// ----------------------------------------------------------------------------
// tam_pkg
// Widths, constants, stage payload types and the arctangent table of the
// triangle area and minimum angle pipeline.
// ----------------------------------------------------------------------------
package tam_pkg;

  localparam int SW     = 16;           // side width
  localparam int SUMW   = SW + 1;       // pair sum and difference width
  localparam int PERW   = SW + 2;       // perimeter width
  localparam int M1W    = PERW + SUMW;  // perimeter times difference
  localparam int M2W    = 2 * SUMW;     // difference times difference
  localparam int HALFW  = SUMW;         // split of the wide product
  localparam int PPW    = M1W + HALFW;  // partial product width
  localparam int PRODW  = 66;           // Heron product, valid triangles
  localparam int SQW    = 2 * SW;       // square of a side
  localparam int XVW    = SQW + 2;      // law of cosines numerator

  localparam int FRAC_SHIFT = 24;
  localparam int RADSH      = 2 * FRAC_SHIFT;
  localparam int ROOTW      = (PRODW + RADSH) / 2;
  localparam int REMW       = ROOTW + 4;
  localparam int AREA_SHIFT = FRAC_SHIFT - 6;
  localparam int AREAW      = 40;

  localparam int NIT  = 28;             // rotation steps
  localparam int XW   = 62;
  localparam int ZW   = 32;
  localparam int ATW  = 28;

  localparam int UNIT_SHIFT   = 10;
  localparam int SECS_PER_DEG = 3600;
  localparam int SECS_PER_MIN = 60;
  localparam int MAX_DEG      = 60;
  localparam int MAX_SECS     = MAX_DEG * SECS_PER_DEG;
  localparam int TW           = 18;
  localparam int RECIP_SHIFT  = 24;
  localparam int RECIP60      = ((1 << RECIP_SHIFT) + SECS_PER_MIN - 1) / SECS_PER_MIN;
  localparam int RCW          = 19;
  localparam int QW           = 12;
  localparam int ANGW         = 6;

  typedef struct packed {
    logic            is_tri;
    logic            equi;
    logic [PERW-1:0] perim;
  } tam_meta_t;

  typedef struct packed {
    tam_meta_t        meta;
    logic [PRODW-1:0] prod;
    logic [XVW-1:0]   xv;
  } tam_heron_t;

  typedef struct packed {
    tam_meta_t        meta;
    logic [ROOTW-1:0] root;
    logic [XVW-1:0]   xv;
  } tam_root_t;

  typedef struct packed {
    tam_meta_t        meta;
    logic [AREAW-1:0] area;
    logic [ZW-1:0]    z;
  } tam_ang_t;

  typedef struct packed {
    logic             is_triangle;
    logic [PERW-1:0]  perimeter;
    logic [AREAW-1:0] area_q8;
    logic [ANGW-1:0]  angle_degrees;
    logic [ANGW-1:0]  angle_minutes;
    logic [ANGW-1:0]  angle_seconds;
  } tam_res_t;

  // Arctangent of 2^-k in 1/1024 arc second, rounded to nearest.
  function automatic logic [ATW-1:0] atan_lut(input logic [4:0] k);
    logic [ATW-1:0] v;
    case (k)
      5'd0:    v = 28'd165888000;
      5'd1:    v = 28'd97929405;
      5'd2:    v = 28'd51743208;
      5'd3:    v = 28'd26265660;
      5'd4:    v = 28'd13183799;
      5'd5:    v = 28'd6598326;
      5'd6:    v = 28'd3299968;
      5'd7:    v = 28'd1650085;
      5'd8:    v = 28'd825055;
      5'd9:    v = 28'd412529;
      5'd10:   v = 28'd206265;
      5'd11:   v = 28'd103132;
      5'd12:   v = 28'd51566;
      5'd13:   v = 28'd25783;
      5'd14:   v = 28'd12892;
      5'd15:   v = 28'd6446;
      5'd16:   v = 28'd3223;
      5'd17:   v = 28'd1611;
      5'd18:   v = 28'd806;
      5'd19:   v = 28'd403;
      5'd20:   v = 28'd201;
      5'd21:   v = 28'd101;
      5'd22:   v = 28'd50;
      5'd23:   v = 28'd25;
      5'd24:   v = 28'd13;
      5'd25:   v = 28'd6;
      5'd26:   v = 28'd3;
      5'd27:   v = 28'd2;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

>>> hw/rtl/tam_if.sv
// ----------------------------------------------------------------------------
// tam_if
// Valid/ready channels for side triples and for results.
// ----------------------------------------------------------------------------
interface tam_in_if
  import tam_pkg::*;
();
  logic          valid;
  logic          ready;
  logic [SW-1:0] side_a;
  logic [SW-1:0] side_b;
  logic [SW-1:0] side_c;

  modport source (output valid, side_a, side_b, side_c, input ready);
  modport sink   (input valid, side_a, side_b, side_c, output ready);
endinterface

interface tam_out_if
  import tam_pkg::*;
();
  logic             valid;
  logic             ready;
  logic             is_triangle;
  logic [PERW-1:0]  perimeter;
  logic [AREAW-1:0] area_q8;
  logic [ANGW-1:0]  angle_degrees;
  logic [ANGW-1:0]  angle_minutes;
  logic [ANGW-1:0]  angle_seconds;

  modport source (output valid, is_triangle, perimeter, area_q8, angle_degrees,
                  angle_minutes, angle_seconds, input ready);
  modport sink   (input valid, is_triangle, perimeter, area_q8, angle_degrees,
                  angle_minutes, angle_seconds, output ready);
endinterface

>>> hw/rtl/triangle_area_min_angle_top.sv
// ----------------------------------------------------------------------------
// triangle_area_min_angle_top
// Heron area, perimeter and smallest angle of a side triple, one triple per
// clock through a valid-tagged pipeline.
// ----------------------------------------------------------------------------
//   channel  | direction | beat contents
//   in_ch    | input     | side_a, side_b, side_c
//   out_ch   | output    | is_triangle, perimeter, area_q8, angle d/m/s
//
// One beat is taken per clock unless out_ch stalls; a result passes through
// 94 register stages:
// 4 front stages, 57 square root stages (one root bit each), 28 rotation
// stages and 5 conversion stages, the last being the output register.
// Reset clears all stage valid bits. While out_ch holds a beat that is not
// taken, the whole pipeline holds and in_ch.ready is low.
// ----------------------------------------------------------------------------
module triangle_area_min_angle_top
  import tam_pkg::*;
#(
  parameter int SIDE_BITS = 16
) (
  input  logic clk,
  input  logic rst_n,
  tam_in_if.sink    in_ch,
  tam_out_if.source out_ch
);

  logic       en;
  logic       f_vld, s_vld, c_vld, d_vld;
  tam_heron_t f_data;
  tam_root_t  s_data;
  tam_ang_t   c_data;
  tam_res_t   res;

  assign en          = !d_vld || out_ch.ready;
  assign in_ch.ready = en;

  tam_front #(.SIDE_BITS(SIDE_BITS)) u_front (
    .clk(clk), .rst_n(rst_n), .en(en),
    .vld_i(in_ch.valid && en),
    .side_a(in_ch.side_a), .side_b(in_ch.side_b), .side_c(in_ch.side_c),
    .vld_o(f_vld), .data_o(f_data)
  );

  tam_sqrt u_sqrt (
    .clk(clk), .rst_n(rst_n), .en(en),
    .vld_i(f_vld), .data_i(f_data), .vld_o(s_vld), .data_o(s_data)
  );

  tam_cordic u_cordic (
    .clk(clk), .rst_n(rst_n), .en(en),
    .vld_i(s_vld), .data_i(s_data), .vld_o(c_vld), .data_o(c_data)
  );

  tam_dms u_dms (
    .clk(clk), .rst_n(rst_n), .en(en),
    .vld_i(c_vld), .data_i(c_data), .vld_o(d_vld), .res_o(res)
  );

  assign out_ch.valid         = d_vld;
  assign out_ch.is_triangle   = res.is_triangle;
  assign out_ch.perimeter     = res.perimeter;
  assign out_ch.area_q8       = res.area_q8;
  assign out_ch.angle_degrees = res.angle_degrees;
  assign out_ch.angle_minutes = res.angle_minutes;
  assign out_ch.angle_seconds = res.angle_seconds;

endmodule

>>> hw/rtl/tam_front.sv
// ----------------------------------------------------------------------------
// tam_front
// Four stages: triangle test and differences, products and squares, split
// wide product and cosine numerator, final Heron product.
// ----------------------------------------------------------------------------
module tam_front
  import tam_pkg::*;
#(
  parameter int SIDE_BITS = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          vld_i,
  input  logic [SW-1:0] side_a,
  input  logic [SW-1:0] side_b,
  input  logic [SW-1:0] side_c,
  output logic          vld_o,
  output tam_heron_t    data_o
);

  localparam int MB = (SIDE_BITS < SW) ? SIDE_BITS : SW;
  localparam logic [SW-1:0] SIDE_MASK = SW'((64'd1 << MB) - 64'd1);

  logic [3:0] vld_r;

  // stage 1
  logic [SW-1:0]   a, b, c, s_nxt, o1_nxt, o2_nxt;
  logic [SUMW-1:0] sab, sac, sbc;
  tam_meta_t       meta1_r, meta2_r, meta3_r, meta4_r;
  logic [SUMW-1:0] d1_r, d2_r, d3_r;
  logic [SW-1:0]   s_r, o1_r, o2_r;
  // stage 2
  logic [M1W-1:0]  m1_r;
  logic [M2W-1:0]  m2_r;
  logic [SQW-1:0]  sqs_r, sq1_r, sq2_r;
  // stage 3
  logic [PPW-1:0]  pl_r, ph_r;
  logic [XVW-1:0]  xv3_r, xv4_r;
  // stage 4
  logic [PRODW-1:0] prod_r;

  always_comb begin
    a   = side_a & SIDE_MASK;
    b   = side_b & SIDE_MASK;
    c   = side_c & SIDE_MASK;
    sab = SUMW'(a) + SUMW'(b);
    sac = SUMW'(a) + SUMW'(c);
    sbc = SUMW'(b) + SUMW'(c);
    s_nxt  = a;
    o1_nxt = b;
    o2_nxt = c;
    if (b < s_nxt) begin
      s_nxt  = b;
      o1_nxt = a;
      o2_nxt = c;
    end
    if (c < s_nxt) begin
      s_nxt  = c;
      o1_nxt = a;
      o2_nxt = b;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[2:0], vld_i};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      meta1_r.is_tri <= (sab > SUMW'(c)) && (sac > SUMW'(b)) && (sbc > SUMW'(a));
      meta1_r.equi   <= (a == b) && (b == c);
      meta1_r.perim  <= PERW'(sab) + PERW'(c);
      d1_r <= sbc - SUMW'(a);
      d2_r <= sac - SUMW'(b);
      d3_r <= sab - SUMW'(c);
      s_r  <= s_nxt;
      o1_r <= o1_nxt;
      o2_r <= o2_nxt;

      meta2_r <= meta1_r;
      m1_r    <= M1W'(meta1_r.perim) * M1W'(d1_r);
      m2_r    <= M2W'(d2_r) * M2W'(d3_r);
      sqs_r   <= SQW'(s_r) * SQW'(s_r);
      sq1_r   <= SQW'(o1_r) * SQW'(o1_r);
      sq2_r   <= SQW'(o2_r) * SQW'(o2_r);

      // The 35 x 34 bit product is taken as two 35 x 17 bit halves.
      meta3_r <= meta2_r;
      pl_r    <= PPW'(m1_r) * PPW'(m2_r[HALFW-1:0]);
      ph_r    <= PPW'(m1_r) * PPW'(m2_r[M2W-1:HALFW]);
      xv3_r   <= XVW'(sq1_r) + XVW'(sq2_r) - XVW'(sqs_r);

      meta4_r <= meta3_r;
      prod_r  <= PRODW'(pl_r) + (PRODW'(ph_r) << HALFW);
      xv4_r   <= xv3_r;
    end
  end

  assign vld_o       = vld_r[3];
  assign data_o.meta = meta4_r;
  assign data_o.prod = prod_r;
  assign data_o.xv   = xv4_r;

endmodule

>>> hw/rtl/tam_sqrt.sv
// ----------------------------------------------------------------------------
// tam_sqrt
// Digit-by-digit square root of the Heron product scaled by 2^48, one root
// bit per stage.
// ----------------------------------------------------------------------------
module tam_sqrt
  import tam_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       en,
  input  logic       vld_i,
  input  tam_heron_t data_i,
  output logic       vld_o,
  output tam_root_t  data_o
);

  logic             src_vld  [ROOTW];
  tam_meta_t        src_meta [ROOTW];
  logic [XVW-1:0]   src_xv   [ROOTW];
  logic [PRODW-1:0] src_prod [ROOTW];
  logic [REMW-1:0]  src_rem  [ROOTW];
  logic [ROOTW-1:0] src_root [ROOTW];

  logic             vld_r  [ROOTW];
  tam_meta_t        meta_r [ROOTW];
  logic [XVW-1:0]   xv_r   [ROOTW];
  logic [PRODW-1:0] prod_r [ROOTW];
  logic [REMW-1:0]  rem_r  [ROOTW];
  logic [ROOTW-1:0] root_r [ROOTW];

  for (genvar k = 0; k < ROOTW; k++) begin : g_stage
    localparam int BI = ROOTW - 1 - k;

    logic [1:0]      pair;
    logic [REMW-1:0] rem_sh, trial;

    if (k == 0) begin : g_src
      assign src_vld[k]  = vld_i;
      assign src_meta[k] = data_i.meta;
      assign src_xv[k]   = data_i.xv;
      assign src_prod[k] = data_i.prod;
      assign src_rem[k]  = '0;
      assign src_root[k] = '0;
    end else begin : g_src
      assign src_vld[k]  = vld_r[k-1];
      assign src_meta[k] = meta_r[k-1];
      assign src_xv[k]   = xv_r[k-1];
      assign src_prod[k] = prod_r[k-1];
      assign src_rem[k]  = rem_r[k-1];
      assign src_root[k] = root_r[k-1];
    end

    // The radicand's low 48 bits are zero.
    if (2 * BI >= RADSH) begin : g_pair
      assign pair = src_prod[k][2*BI-RADSH +: 2];
    end else begin : g_pair
      assign pair = 2'b00;
    end

    assign rem_sh = {src_rem[k][REMW-3:0], pair};
    assign trial  = REMW'({src_root[k], 2'b01});

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= src_vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        meta_r[k] <= src_meta[k];
        xv_r[k]   <= src_xv[k];
        prod_r[k] <= src_prod[k];
        if (rem_sh >= trial) begin
          rem_r[k]  <= rem_sh - trial;
          root_r[k] <= {src_root[k][ROOTW-2:0], 1'b1};
        end else begin
          rem_r[k]  <= rem_sh;
          root_r[k] <= {src_root[k][ROOTW-2:0], 1'b0};
        end
      end
    end
  end

  assign vld_o       = vld_r[ROOTW-1];
  assign data_o.meta = meta_r[ROOTW-1];
  assign data_o.root = root_r[ROOTW-1];
  assign data_o.xv   = xv_r[ROOTW-1];

endmodule

>>> hw/rtl/tam_cordic.sv
// ----------------------------------------------------------------------------
// tam_cordic
// Vectoring rotations from (xv * 2^24, root), one rotation per stage, that
// accumulate the smallest angle in 1/1024 arc second.
// ----------------------------------------------------------------------------
module tam_cordic
  import tam_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      en,
  input  logic      vld_i,
  input  tam_root_t data_i,
  output logic      vld_o,
  output tam_ang_t  data_o
);

  logic                    src_vld  [NIT];
  tam_meta_t               src_meta [NIT];
  logic [AREAW-1:0]        src_area [NIT];
  logic signed [XW-1:0]    src_x    [NIT];
  logic signed [XW-1:0]    src_y    [NIT];
  logic signed [ZW-1:0]    src_z    [NIT];

  logic                    vld_r  [NIT];
  tam_meta_t               meta_r [NIT];
  logic [AREAW-1:0]        area_r [NIT];
  logic signed [XW-1:0]    x_r    [NIT];
  logic signed [XW-1:0]    y_r    [NIT];
  logic signed [ZW-1:0]    z_r    [NIT];

  for (genvar k = 0; k < NIT; k++) begin : g_stage
    localparam logic signed [ZW-1:0] ATAN_K = ZW'(atan_lut(5'(k)));

    logic signed [XW-1:0] dx, dy;

    if (k == 0) begin : g_src
      assign src_vld[k]  = vld_i;
      assign src_meta[k] = data_i.meta;
      // The area is the same root taken to 8 fractional bits.
      assign src_area[k] = AREAW'(data_i.root >> AREA_SHIFT);
      assign src_x[k]    = $signed(XW'(data_i.xv) << FRAC_SHIFT);
      assign src_y[k]    = $signed(XW'(data_i.root));
      assign src_z[k]    = '0;
    end else begin : g_src
      assign src_vld[k]  = vld_r[k-1];
      assign src_meta[k] = meta_r[k-1];
      assign src_area[k] = area_r[k-1];
      assign src_x[k]    = x_r[k-1];
      assign src_y[k]    = y_r[k-1];
      assign src_z[k]    = z_r[k-1];
    end

    assign dx = src_y[k] >>> k;
    assign dy = src_x[k] >>> k;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= src_vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        meta_r[k] <= src_meta[k];
        area_r[k] <= src_area[k];
        if (src_y[k] > 0) begin
          x_r[k] <= src_x[k] + dx;
          y_r[k] <= src_y[k] - dy;
          z_r[k] <= src_z[k] + ATAN_K;
        end else begin
          x_r[k] <= src_x[k] - dx;
          y_r[k] <= src_y[k] + dy;
          z_r[k] <= src_z[k] - ATAN_K;
        end
      end
    end
  end

  assign vld_o       = vld_r[NIT-1];
  assign data_o.meta = meta_r[NIT-1];
  assign data_o.area = area_r[NIT-1];
  assign data_o.z    = z_r[NIT-1];

endmodule

>>> hw/rtl/tam_dms.sv
// ----------------------------------------------------------------------------
// tam_dms
// Splits the angle into degrees, minutes and seconds by reciprocal
// multiplication and forms the result register.
// ----------------------------------------------------------------------------
module tam_dms
  import tam_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     en,
  input  logic     vld_i,
  input  tam_ang_t data_i,
  output logic     vld_o,
  output tam_res_t res_o
);

  localparam int TFW = ZW - UNIT_SHIFT;
  localparam int P1W = TW + RCW;
  localparam int P2W = QW + RCW;

  logic [4:0]       vld_r;
  tam_meta_t        meta1_r, meta2_r, meta3_r, meta4_r;
  logic [AREAW-1:0] area1_r, area2_r, area3_r, area4_r;
  logic [TW-1:0]    t1_r, t2_r;
  logic [P1W-1:0]   p1_r;
  logic [QW-1:0]    q3_r, q4_r;
  logic [ANGW-1:0]  sec3_r, sec4_r;
  logic [P2W-1:0]   p2_r;
  tam_res_t         res_r;

  logic [TFW-1:0]   tfull;
  logic [TW-1:0]    t_nxt;
  logic [QW-1:0]    q_nxt, deg_q;
  logic [TW-1:0]    q60;
  logic [QW-1:0]    deg60;
  logic [ANGW-1:0]  deg_nxt, min_nxt;

  always_comb begin
    // Negative angles count as zero; the angle is capped at 60 degrees.
    tfull = data_i.z[ZW-1] ? '0 : TFW'(data_i.z >> UNIT_SHIFT);
    t_nxt = (tfull > TFW'(MAX_SECS)) ? TW'(MAX_SECS) : TW'(tfull);
    q_nxt = QW'(p1_r >> RECIP_SHIFT);
    q60   = TW'(q_nxt) * TW'(SECS_PER_MIN);
    deg_q = QW'(p2_r >> RECIP_SHIFT);
    deg60 = deg_q * QW'(SECS_PER_MIN);
    deg_nxt = ANGW'(deg_q);
    min_nxt = ANGW'(q4_r - deg60);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[3:0], vld_i};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      meta1_r <= data_i.meta;
      area1_r <= data_i.area;
      t1_r    <= t_nxt;

      meta2_r <= meta1_r;
      area2_r <= area1_r;
      t2_r    <= t1_r;
      p1_r    <= P1W'(t1_r) * P1W'(RECIP60);

      meta3_r <= meta2_r;
      area3_r <= area2_r;
      q3_r    <= q_nxt;
      sec3_r  <= ANGW'(t2_r - q60);

      meta4_r <= meta3_r;
      area4_r <= area3_r;
      q4_r    <= q3_r;
      sec4_r  <= sec3_r;
      p2_r    <= P2W'(q3_r) * P2W'(RECIP60);

      res_r.is_triangle <= meta4_r.is_tri;
      if (!meta4_r.is_tri) begin
        res_r.perimeter     <= '0;
        res_r.area_q8       <= '0;
        res_r.angle_degrees <= '0;
        res_r.angle_minutes <= '0;
        res_r.angle_seconds <= '0;
      end else begin
        res_r.perimeter <= meta4_r.perim;
        res_r.area_q8   <= area4_r;
        if (meta4_r.equi) begin
          res_r.angle_degrees <= ANGW'(MAX_DEG);
          res_r.angle_minutes <= '0;
          res_r.angle_seconds <= '0;
        end else begin
          res_r.angle_degrees <= deg_nxt;
          res_r.angle_minutes <= min_nxt;
          res_r.angle_seconds <= sec4_r;
        end
      end
    end
  end

  assign vld_o = vld_r[4];
  assign res_o = res_r;

endmodule

>>> hw/rtl/tam_checker.sv
// ----------------------------------------------------------------------------
// tam_checker
// Port-level checks of the triangle pipeline, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tam_checker
  import tam_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic             is_triangle,
  input logic [PERW-1:0]  perimeter,
  input logic [AREAW-1:0] area_q8,
  input logic [ANGW-1:0]  deg,
  input logic [ANGW-1:0]  mins,
  input logic [ANGW-1:0]  secs
);

  logic in_beat;
  assign in_beat = in_valid && in_ready;

  // An empty output register never blocks the input side.
  `TAM_ASSERT(a_ready_when_empty, !out_valid |-> in_ready)

  `TAM_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(area_q8) && $stable(perimeter))

  // A rejected triple carries nothing but zeros.
  `TAM_NEVER(a_reject_zero, out_valid && !is_triangle && (perimeter != 0 || area_q8 != 0 || deg != 0 || mins != 0 || secs != 0))

  // A valid triangle has a nonzero perimeter and an angle of at most 60 degrees.
  `TAM_NEVER(a_angle_range, out_valid && is_triangle && (perimeter == 0 || deg > 6'd60 || mins > 6'd59 || secs > 6'd59 || (deg == 6'd60 && (mins != 0 || secs != 0))))

  `TAM_NEVER(a_stall_blocks, in_beat && out_valid && !out_ready)

endmodule

bind triangle_area_min_angle_top tam_checker u_tam_checker (
  .clk(clk), .rst_n(rst_n),
  .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .is_triangle(out_ch.is_triangle), .perimeter(out_ch.perimeter),
  .area_q8(out_ch.area_q8), .deg(out_ch.angle_degrees),
  .mins(out_ch.angle_minutes), .secs(out_ch.angle_seconds)
);

>>> bench/triangle_area_min_angle_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangle_area_min_angle_top_tb
// Streams side triples into the Heron area and smallest angle pipeline. A
// scoreboard computes perimeter, area and the CORDIC angle of each accepted
// beat and checks every result beat in order. Both channels idle at random.
// ----------------------------------------------------------------------------
module triangle_area_min_angle_top_tb;
  import tam_pkg::*;

  localparam int ITEMS     = 1350;
  localparam int QUIET     = 200;
  localparam int MAX_CYCLE = 400000;

  class heron_scoreboard;
    tam_res_t expected_q[$];
    int       errors;

    function new();
      errors = 0;
    endfunction

    static function logic [127:0] root_floor(logic [127:0] n, int top);
      logic [127:0] r;
      logic [127:0] t;
      r = '0;
      for (int b = top; b >= 0; b--) begin
        t = r | (128'd1 << b);
        if (t * t <= n) r = t;
      end
      return r;
    endfunction

    static function tam_res_t triangle_figures(logic [15:0] a, logic [15:0] b, logic [15:0] c);
      tam_res_t     res;
      longint       sa, sb, sc, sm, o1, o2;
      logic [127:0] prod;
      logic [127:0] yv;
      longint       x, y, z, dx, dy;
      longint       tsec;
      res = '0;
      sa = a; sb = b; sc = c;
      if (sa + sb <= sc || sa + sc <= sb || sb + sc <= sa) return res;
      prod = 128'(sa + sb + sc) * 128'(sb + sc - sa) * 128'(sa + sc - sb) * 128'(sa + sb - sc);
      res.is_triangle = 1'b1;
      res.perimeter   = PERW'(sa + sb + sc);
      res.area_q8     = AREAW'(root_floor(prod << 12, 39));
      if (sa == sb && sb == sc) begin
        res.angle_degrees = ANGW'(MAX_DEG);
        return res;
      end
      sm = sa; o1 = sb; o2 = sc;
      if (sb < sm) begin sm = sb; o1 = sa; o2 = sc; end
      if (sc < sm) begin sm = sc; o1 = sa; o2 = sb; end
      yv = root_floor(prod << 48, 58);
      x = (o1 * o1 + o2 * o2 - sm * sm) <<< FRAC_SHIFT;
      y = longint'(yv[63:0]);
      z = 0;
      for (int i = 0; i < NIT; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (y > 0) begin
          x += dx; y -= dy; z += longint'(atan_lut(5'(i)));
        end else begin
          x -= dx; y += dy; z -= longint'(atan_lut(5'(i)));
        end
      end
      if (z < 0) z = 0;
      tsec = z >> UNIT_SHIFT;
      if (tsec > MAX_SECS) tsec = MAX_SECS;
      res.angle_degrees = ANGW'(tsec / SECS_PER_DEG);
      res.angle_minutes = ANGW'((tsec / SECS_PER_MIN) % 60);
      res.angle_seconds = ANGW'(tsec % SECS_PER_MIN);
      return res;
    endfunction

    function void note_triple(logic [15:0] a, logic [15:0] b, logic [15:0] c);
      expected_q.push_back(triangle_figures(a, b, c));
    endfunction

    function void check_result(tam_res_t got);
      tam_res_t want;
      if (expected_q.size() == 0) begin
        $error("result beat with nothing expected");
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (got.is_triangle !== want.is_triangle) begin
        $error("is_triangle: expected %0d, got %0d", want.is_triangle, got.is_triangle);
        errors++;
      end
      if (got.perimeter !== want.perimeter) begin
        $error("perimeter: expected %0d, got %0d", want.perimeter, got.perimeter);
        errors++;
      end
      if (got.area_q8 !== want.area_q8) begin
        $error("area_q8: expected %0d, got %0d", want.area_q8, got.area_q8);
        errors++;
      end
      if (got.angle_degrees !== want.angle_degrees) begin
        $error("angle_degrees: expected %0d, got %0d", want.angle_degrees, got.angle_degrees);
        errors++;
      end
      if (got.angle_minutes !== want.angle_minutes) begin
        $error("angle_minutes: expected %0d, got %0d", want.angle_minutes, got.angle_minutes);
        errors++;
      end
      if (got.angle_seconds !== want.angle_seconds) begin
        $error("angle_seconds: expected %0d, got %0d", want.angle_seconds, got.angle_seconds);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  int   cycle_count;
  bit   quiet_phase;
  heron_scoreboard board;

  tam_in_if  in_ch ();
  tam_out_if out_ch ();

  triangle_area_min_angle_top u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  initial begin
    board        = new();
    cycle_count  = 0;
    quiet_phase  = 1'b0;
    rst_n        = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.side_a = '0;
    in_ch.side_b = '0;
    in_ch.side_c = '0;
    out_ch.ready = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > MAX_CYCLE) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Beats are sampled at the rising edge, after the falling-edge drive settled.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready)
        board.note_triple(in_ch.side_a, in_ch.side_b, in_ch.side_c);
      if (out_ch.valid && out_ch.ready)
        board.check_result({out_ch.is_triangle, out_ch.perimeter, out_ch.area_q8,
                            out_ch.angle_degrees, out_ch.angle_minutes,
                            out_ch.angle_seconds});
    end
  end

  // Receiver stalls in bursts, with open stretches in between.
  always @(negedge clk) begin : recv_stall
    int left;
    if (rst_n) begin
      if (quiet_phase) begin
        out_ch.ready <= 1'b1;
      end else if (left > 0) begin
        left--;
        out_ch.ready <= 1'b0;
      end else if ($urandom_range(0, 9) == 0) begin
        left = $urandom_range(1, 7) - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  task automatic send_triple(logic [15:0] a, logic [15:0] b, logic [15:0] c);
    int gap;
    if (!quiet_phase && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 7);
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid  <= 1'b1;
    in_ch.side_a <= a;
    in_ch.side_b <= b;
    in_ch.side_c <= c;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [15:0] scaled_side();
    int w;
    w = $urandom_range(1, 16);
    return 16'($urandom_range(1, (1 << w) - 1));
  endfunction

  task automatic send_random();
    logic [15:0] a, b, c;
    int lo, hi, kind;
    kind = $urandom_range(0, 9);
    a = scaled_side();
    b = scaled_side();
    if (kind == 0) begin
      a = 16'($urandom); b = 16'($urandom); c = 16'($urandom);
    end else if (kind == 1) begin
      b = a; c = a;
    end else if (kind == 2) begin
      c = a;
    end else begin
      lo = (a > b) ? a - b + 1 : b - a + 1;
      hi = int'(a) + int'(b) - 1;
      if (hi > 65535) hi = 65535;
      c = 16'($urandom_range(lo, hi));
    end
    case ($urandom_range(0, 2))
      0: send_triple(a, b, c);
      1: send_triple(c, a, b);
      default: send_triple(b, c, a);
    endcase
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_triple(16'd0, 16'd0, 16'd0);
    send_triple(16'd0, 16'd5, 16'd5);
    send_triple(16'd1, 16'd1, 16'd2);
    send_triple(16'd1, 16'd1, 16'd1);
    send_triple(16'd3, 16'd4, 16'd5);
    send_triple(16'd5, 16'd3, 16'd4);
    send_triple(16'd4, 16'd5, 16'd3);
    send_triple(16'd2, 16'd2, 16'd3);
    send_triple(16'd3, 16'd2, 16'd2);
    send_triple(16'd65535, 16'd65535, 16'd65535);
    send_triple(16'd65535, 16'd65535, 16'd1);
    send_triple(16'd1, 16'd65535, 16'd65535);
    send_triple(16'd65535, 16'd65534, 16'd1);
    send_triple(16'd65535, 16'd32768, 16'd32768);
    send_triple(16'd65535, 16'd32767, 16'd32768);
    send_triple(16'd65535, 16'd0, 16'd65535);
    send_triple(16'd2, 16'd65535, 16'd65534);
    send_triple(16'd7, 16'd7, 16'd13);
    send_triple(16'd43690, 16'd21845, 16'd43690);

    for (int n = 0; n < ITEMS; n++) begin
      if (n == ITEMS - QUIET) quiet_phase = 1'b1;
      send_random();
    end
    in_ch.valid <= 1'b0;

    while (board.expected_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (board.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+hw/rtl
hw/rtl/tam_pkg.sv
hw/rtl/tam_if.sv
hw/rtl/tam_front.sv
hw/rtl/tam_sqrt.sv
hw/rtl/tam_cordic.sv
hw/rtl/tam_dms.sv
hw/rtl/triangle_area_min_angle_top.sv
hw/rtl/tam_checker.sv
bench/triangle_area_min_angle_top_tb.sv
